// File: sv/dipt_pkg.sv
// Shared types and constants for the dotted IPv4 text parser.
// No dependencies; imported by the front, queue, back and top modules.
package dipt_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [31:0] LIMIT_ONE_BYTE    = 32'h0000_00ff;
   localparam logic [31:0] LIMIT_TWO_BYTES   = 32'h0000_ffff;
   localparam logic [31:0] LIMIT_THREE_BYTES = 32'h00ff_ffff;

   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_HEXLET,
      CLS_X,
      CLS_DOT,
      CLS_SPACE,
      CLS_END,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [3:0]     val;
   } char_word_type;

endpackage

// File: sv/dotted_ipv4_text_parser_unit.sv
// Dotted IPv4 text parser: one character word per cycle, one result per zero byte.
// Throughput: one character accepted every cycle while the queue has room.
// Path: the zero byte goes from the classifier into a 4-word queue, then the parser
// writes the result register; a result still held under rsp_stall blocks that write.
// Reset: queue emptied, parser back at start of part, no result pending.
// Depends on dipt_pkg, dipt_front, dipt_queue, dipt_back.
module dotted_ipv4_text_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [31:0] rsp_address
);
   import dipt_pkg::*;

   char_word_type class_word;
   char_word_type head_word;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;

   assign req_stall = q_full;

   dipt_front u_front (
      .text_char (req_text_char),
      .word_out  (class_word)
   );

   dipt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_word (class_word),
      .full      (q_full),
      .pop       (q_pop),
      .head_word (head_word),
      .empty     (q_empty)
   );

   dipt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .word_valid  (!q_empty),
      .word_in     (head_word),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_ok      (rsp_ok),
      .rsp_address (rsp_address)
   );

endmodule

// File: sv/dipt_front.sv
// Front end: classifies one text character into a class code and digit value.
// Depends on dipt_pkg.
module dipt_front (
   input  logic [7:0]             text_char,
   output dipt_pkg::char_word_type word_out
);
   import dipt_pkg::*;

   always_comb begin
      word_out.val = text_char[3:0];
      if (text_char == 8'h00) begin
         word_out.cls = CLS_END;
      end else if (text_char >= 8'h30 && text_char <= 8'h39) begin
         word_out.cls = CLS_DIGIT;
      end else if ((text_char >= 8'h61 && text_char <= 8'h66) ||
                   (text_char >= 8'h41 && text_char <= 8'h46)) begin
         // 'a'/'A' have low nibble 1, value 10
         word_out.cls = CLS_HEXLET;
         word_out.val = text_char[3:0] + 4'd9;
      end else if (text_char == 8'h78 || text_char == 8'h58) begin
         word_out.cls = CLS_X;
      end else if (text_char == 8'h2e) begin
         word_out.cls = CLS_DOT;
      end else if (text_char == 8'h20 || (text_char >= 8'h09 && text_char <= 8'h0d)) begin
         word_out.cls = CLS_SPACE;
      end else begin
         word_out.cls = CLS_OTHER;
      end
   end

endmodule

// File: sv/dipt_queue.sv
// Short FIFO of classified character words between front and back.
// Depends on dipt_pkg.
module dipt_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dipt_pkg::char_word_type push_word,
   output logic                    full,
   input  logic                    pop,
   output dipt_pkg::char_word_type head_word,
   output logic                    empty
);
   import dipt_pkg::*;

   char_word_type       slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign head_word = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_word;
      end
   end

endmodule

// File: sv/dipt_back.sv
// Back end: parse state machine over classified words, builds the address
// and holds the result register. Depends on dipt_pkg.
module dipt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    word_valid,
   input  dipt_pkg::char_word_type word_in,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_ok,
   output logic [31:0]             rsp_address
);
   import dipt_pkg::*;

   typedef enum logic [2:0] {
      PH_START,
      PH_ZERO,
      PH_DIGITS,
      PH_SKIP,
      PH_ERROR
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_OCT,
      RADIX_HEX
   } radix_type;

   phase_type   phase_ff, phase_in;
   radix_type   radix_ff, radix_in;
   radix_type   eff_radix;
   logic [31:0] accum_ff, accum_in;
   logic [7:0]  part_ff [3];
   logic [7:0]  part_in [3];
   logic [1:0]  count_ff, count_in;
   logic        valid_ff, valid_in;
   logic        ok_ff, ok_in;
   logic [31:0] addr_ff, addr_in;

   logic        is_end;
   logic        good;
   logic [31:0] built;
   logic [31:0] scaled;
   logic [31:0] digit_next;

   assign is_end = (word_in.cls == CLS_END);
   // a result can only be written when the output register is free
   assign pop = word_valid && (!is_end || !valid_ff || !rsp_stall);

   assign rsp_valid   = valid_ff;
   assign rsp_ok      = ok_ff;
   assign rsp_address = addr_ff;

   // after a leading zero the part is octal unless an x follows
   assign eff_radix = (phase_ff == PH_ZERO) ? RADIX_OCT : radix_ff;

   always_comb begin
      case (eff_radix)
         RADIX_HEX: scaled = {accum_ff[27:0], 4'b0};
         RADIX_OCT: scaled = {accum_ff[28:0], 3'b0};
         default:   scaled = {accum_ff[28:0], 3'b0} + {accum_ff[30:0], 1'b0};
      endcase
      digit_next = scaled + {28'b0, word_in.val};
   end

   // final assembly of the 1..4 part form
   always_comb begin
      good  = (phase_ff != PH_ERROR);
      built = accum_ff;
      case (count_ff)
         2'd1: begin
            if (accum_ff > LIMIT_THREE_BYTES) good = 1'b0;
            built = accum_ff | {part_ff[0], 24'b0};
         end
         2'd2: begin
            if (accum_ff > LIMIT_TWO_BYTES) good = 1'b0;
            built = accum_ff | {part_ff[0], part_ff[1], 16'b0};
         end
         2'd3: begin
            if (accum_ff > LIMIT_ONE_BYTE) good = 1'b0;
            built = accum_ff | {part_ff[0], part_ff[1], part_ff[2], 8'b0};
         end
         default: begin
            built = accum_ff;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      radix_in = radix_ff;
      accum_in = accum_ff;
      part_in  = part_ff;
      count_in = count_ff;
      valid_in = valid_ff && rsp_stall;
      ok_in    = ok_ff;
      addr_in  = addr_ff;

      if (pop) begin
         if (is_end) begin
            valid_in = 1'b1;
            ok_in    = good;
            addr_in  = good ? built : 32'b0;
            phase_in = PH_START;
            radix_in = RADIX_DEC;
            accum_in = '0;
            part_in  = '{default: 8'b0};
            count_in = '0;
         end else begin
            case (phase_ff)
               PH_START, PH_ZERO, PH_DIGITS: begin
                  if (phase_ff == PH_START && word_in.cls == CLS_DIGIT &&
                      word_in.val == 4'd0) begin
                     phase_in = PH_ZERO;
                  end else if (phase_ff == PH_ZERO && word_in.cls == CLS_X) begin
                     radix_in = RADIX_HEX;
                     phase_in = PH_DIGITS;
                  end else begin
                     radix_in = eff_radix;
                     phase_in = PH_DIGITS;
                     if (word_in.cls == CLS_DIGIT ||
                         (word_in.cls == CLS_HEXLET && eff_radix == RADIX_HEX)) begin
                        accum_in = digit_next;
                     end else if (word_in.cls == CLS_DOT) begin
                        if (count_ff == 2'd3 || accum_ff > LIMIT_ONE_BYTE) begin
                           phase_in = PH_ERROR;
                        end else begin
                           part_in[count_ff] = accum_ff[7:0];
                           count_in = count_ff + 1'b1;
                           accum_in = '0;
                           radix_in = RADIX_DEC;
                           phase_in = PH_START;
                        end
                     end else if (word_in.cls == CLS_SPACE) begin
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_ERROR;
                     end
                  end
               end
               PH_SKIP: begin
                  phase_in = PH_SKIP;
               end
               default: begin
                  phase_in = PH_ERROR;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         radix_ff <= RADIX_DEC;
         accum_ff <= '0;
         part_ff  <= '{default: 8'b0};
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         accum_ff <= accum_in;
         part_ff  <= part_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      ok_ff   <= ok_in;
      addr_ff <= addr_in;
   end

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !ok_ff) |-> (addr_ff == 32'b0))
      else $error("failed parse carries a nonzero address");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR && !(pop && is_end)) |=> (phase_ff == PH_ERROR))
      else $error("error phase left before end of string");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (pop && is_end) |=> valid_ff && phase_ff == PH_START && count_ff == 2'd0)
      else $error("end of string did not yield a result and clean state");

endmodule

// File: sim/dotted_ipv4_text_parser_unit_test.sv
// Testbench for dotted_ipv4_text_parser_unit: feeds address text one character word at a time
// and checks each ok/address result against a built-in model of the parser.
// Depends on dipt_pkg and the RTL under sv/.

typedef struct {
   bit        ok;
   bit [31:0] address;
} parse_result_type;

typedef enum {SCAN_START, SCAN_ZERO, SCAN_DIGITS, SCAN_SKIP, SCAN_ERROR} scan_state_type;
typedef enum {BASE_DEC, BASE_OCT, BASE_HEX} num_base_type;

class address_scoreboard;
   bit [31:0]        part_value;
   bit [7:0]         closed_parts [3];
   bit [1:0]         closed_count;
   num_base_type     base;
   scan_state_type   scan;
   parse_result_type expected_q[$];
   int               failures;

   function new();
      failures = 0;
      clear_all();
   endfunction

   function void start_part();
      part_value = 0;
      base       = BASE_DEC;
      scan       = SCAN_START;
   endfunction

   function void clear_all();
      closed_parts[0] = 0;
      closed_parts[1] = 0;
      closed_parts[2] = 0;
      closed_count    = 0;
      start_part();
   endfunction

   function bit is_blank(bit [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   // character that stops the digits of a part
   function void close_digits(bit [7:0] c);
      if (c == ".") begin
         if (closed_count == 2'd3 || part_value > dipt_pkg::LIMIT_ONE_BYTE) begin
            scan = SCAN_ERROR;
         end else begin
            closed_parts[closed_count] = part_value[7:0];
            closed_count = closed_count + 2'd1;
            start_part();
         end
      end else if (is_blank(c)) begin
         scan = SCAN_SKIP;
      end else begin
         scan = SCAN_ERROR;
      end
   endfunction

   function void digit_char(bit [7:0] c);
      bit [31:0] mul;
      scan = SCAN_DIGITS;
      if (c >= "0" && c <= "9") begin
         mul = (base == BASE_HEX) ? 32'd16 : ((base == BASE_OCT) ? 32'd8 : 32'd10);
         part_value = part_value * mul + ({24'b0, c} - 32'h30);
      end else if (base == BASE_HEX && c >= "a" && c <= "f") begin
         part_value = (part_value << 4) + ({24'b0, c} - 32'h61 + 32'd10);
      end else if (base == BASE_HEX && c >= "A" && c <= "F") begin
         part_value = (part_value << 4) + ({24'b0, c} - 32'h41 + 32'd10);
      end else begin
         close_digits(c);
      end
   endfunction

   function parse_result_type final_address();
      parse_result_type r;
      bit [31:0]        v;
      v    = part_value;
      r.ok = 1'b1;
      if (scan == SCAN_ERROR) begin
         r.ok = 1'b0;
      end else begin
         case (closed_count)
            2'd0: ;
            2'd1: begin
               if (v > dipt_pkg::LIMIT_THREE_BYTES) r.ok = 1'b0;
               else v = v | {closed_parts[0], 24'b0};
            end
            2'd2: begin
               if (v > dipt_pkg::LIMIT_TWO_BYTES) r.ok = 1'b0;
               else v = v | {closed_parts[0], closed_parts[1], 16'b0};
            end
            default: begin
               if (v > dipt_pkg::LIMIT_ONE_BYTE) r.ok = 1'b0;
               else v = v | {closed_parts[0], closed_parts[1], closed_parts[2], 8'b0};
            end
         endcase
      end
      r.address = r.ok ? v : 32'd0;
      return r;
   endfunction

   // one accepted input word
   function void note_char(bit [7:0] c);
      if (c == 8'h00) begin
         expected_q.push_back(final_address());
         clear_all();
      end else begin
         case (scan)
            SCAN_START: begin
               if (c == "0") scan = SCAN_ZERO;
               else digit_char(c);
            end
            SCAN_ZERO: begin
               if (c == "x" || c == "X") begin
                  base = BASE_HEX;
                  scan = SCAN_DIGITS;
               end else begin
                  base = BASE_OCT;
                  digit_char(c);
               end
            end
            SCAN_DIGITS: digit_char(c);
            SCAN_SKIP: ;
            default: scan = SCAN_ERROR;
         endcase
      end
   endfunction

   function void check_address(bit ok, bit [31:0] address);
      parse_result_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result ok=%0b address=%h", $time, ok, address);
         failures++;
      end else begin
         e = expected_q.pop_front();
         if (ok !== e.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, e.ok, ok);
            failures++;
         end
         if (address !== e.address) begin
            $display("%0t: address expected %h actual %h", $time, e.address, address);
            failures++;
         end
      end
   endfunction

   function int pending_count();
      return expected_q.size();
   endfunction
endclass

module dotted_ipv4_text_parser_unit_test;

   localparam bit [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
   localparam string NOISE_CHARS = "0123456789abcdefxX. ";

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_char = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_ok;
   logic [31:0] rsp_address;

   address_scoreboard board;
   bit [7:0]          text_buf[$];
   int                chars_sent = 0;
   int                send_idle = 0;
   int                recv_idle = 0;
   bit                burst_armed = 0;
   bit                burst_done = 0;
   int                burst_left = 0;

   string directed_texts [24] = '{
      "", "255.255.255.255", "0.0.0.0", "0x7f.1", "0X1.0377.09", "1..2", "0x",
      "4294967296", "0xFFFFFFFF", "1.0xaBcD", "1.2.3.4.5", "256.1", "1.16777216",
      "1.2.65536", "1.2.3.256", "1.2.3.4 x.y", "7\011\377", "\012", "1a", "abc",
      "\377", "12\200", "1.2.3.4\015", "08.9"
   };

   dotted_ipv4_text_parser_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_char (req_text_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ok        (rsp_ok),
      .rsp_address   (rsp_address)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   task automatic send_char(input bit [7:0] c);
      bit stalled;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_char <= c;
      // stall is sampled mid-cycle, where it is settled for the coming edge
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      board.note_char(c);
      chars_sent++;
   endtask

   // sends text_buf followed by the terminating zero word
   task automatic send_text_buf();
      foreach (text_buf[i]) send_char(text_buf[i]);
      send_char(8'h00);
   endtask

   task automatic append_number(input bit [31:0] value, input int form);
      bit [7:0]  digits[$];
      bit [31:0] v;
      bit [31:0] radix;
      bit [7:0]  d;
      bit        upper;
      upper = $urandom_range(1);
      radix = (form == 0) ? 10 : ((form == 1) ? 8 : 16);
      if (form != 0) text_buf.push_back("0");
      if (form == 2) text_buf.push_back(upper ? "X" : "x");
      // a bare hex prefix now and then
      if (form == 2 && $urandom_range(19) == 0) return;
      v = value;
      do begin
         d = 8'(v % radix);
         if (d < 10) digits.push_front(8'h30 + d);
         else digits.push_front((upper ? 8'h41 : 8'h61) + d - 8'd10);
         v = v / radix;
      end while (v != 0);
      foreach (digits[i]) text_buf.push_back(digits[i]);
   endtask

   task automatic make_random_text();
      int        nparts;
      int        kind;
      int        n;
      bit [31:0] value;
      bit [31:0] lim;
      text_buf = {};
      kind = $urandom_range(99);
      if (kind < 12) begin
         // noise: short runs of arbitrary bytes or parser-relevant characters
         n = $urandom_range(6);
         repeat (n) begin
            if ($urandom_range(1)) text_buf.push_back(8'($urandom_range(1, 255)));
            else text_buf.push_back(NOISE_CHARS[$urandom_range(19)]);
         end
         return;
      end
      nparts = ($urandom_range(19) == 0) ? 5 : $urandom_range(1, 4);
      for (int i = 0; i < nparts; i++) begin
         if (i < nparts - 1) begin
            value = ($urandom_range(99) < 8) ? $urandom_range(256, 400) : $urandom_range(255);
         end else begin
            case (nparts)
               1:       lim = 32'hffff_ffff;
               2:       lim = dipt_pkg::LIMIT_THREE_BYTES;
               3:       lim = dipt_pkg::LIMIT_TWO_BYTES;
               default: lim = dipt_pkg::LIMIT_ONE_BYTE;
            endcase
            value = $urandom;
            if ($urandom_range(1)) value = value & 32'hff;
            if ($urandom_range(9) != 0) value = value & lim;
         end
         if ($urandom_range(19) != 0) append_number(value, $urandom_range(2));
         if (i < nparts - 1) text_buf.push_back(".");
      end
      if ($urandom_range(9) == 0) begin
         text_buf.push_back(BLANKS[$urandom_range(5)]);
         n = $urandom_range(3);
         repeat (n) text_buf.push_back(8'($urandom_range(1, 255)));
      end
      if (kind < 27 && text_buf.size() > 0) begin
         text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(1, 255));
      end
   endtask

   // result side: check accepted words, drive stall
   initial begin
      bit        take;
      bit        got_ok;
      bit [31:0] got_address;
      forever begin
         @(negedge clock);
         take        = !reset && rsp_valid === 1'b1 && !rsp_stall;
         got_ok      = rsp_ok;
         got_address = rsp_address;
         @(posedge clock);
         if (take) board.check_address(got_ok, got_address);
         if (burst_armed && !burst_done) begin
            burst_left = 120;
            burst_done = 1;
         end
         if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle);
         end
      end
   end

   initial begin
      board = new();
      send_idle = 21;
      recv_idle = 55;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_texts[k]) begin
         text_buf = {};
         for (int i = 0; i < directed_texts[k].len(); i++) text_buf.push_back(directed_texts[k][i]);
         send_text_buf();
      end
      while (chars_sent < 750) begin
         make_random_text();
         send_text_buf();
      end
      send_idle = 55;
      recv_idle = 21;
      while (chars_sent < 1400) begin
         make_random_text();
         send_text_buf();
      end
      send_idle = 0;
      recv_idle = 0;
      burst_armed = 1;
      while (chars_sent < 2100) begin
         make_random_text();
         send_text_buf();
      end
      req_valid <= 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
